[rtl/core/icrt_pkg.sv]
// Shared types and constants for the inode cache reference-count table.
package icrt_pkg;

    // Table geometry
    localparam int POOL_SIZE  = 8;
    localparam int SLOT_W     = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CNT_W      = $clog2(POOL_SIZE + 1);

    // Field widths
    localparam int OP_W       = 2;
    localparam int INODE_W    = 16;
    localparam int REFS_W     = 8;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 3;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    typedef enum logic [OP_W-1:0] {
        OP_GET    = 2'd0,
        OP_LOCK   = 2'd1,
        OP_UNLOCK = 2'd2,
        OP_PUT    = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_WAIT     = 3'd1,
        ST_FULL     = 3'd2,
        ST_ABSENT   = 3'd3,
        ST_LOCKED   = 3'd4,
        ST_UNLOCKED = 3'd5,
        ST_UNREF    = 3'd6,
        ST_LIMIT    = 3'd7
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } ctrl_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } icrt_cmd_t;

endpackage

[rtl/core/inode_cache_refcount_table.sv]
// In-core inode table with reference counts, lock bits and a free queue of
// released entries. Each request beat (opcode in tuser, inode number in tdata)
// yields exactly one result beat (status in tuser, count and slot in tdata).
// A request beat is captured in the idle state; in the execute state the
// table lookup, the free-queue search and shift and the table update all
// complete and the result register loads. The next request is taken in the
// cycle after that, while the result beat may still wait for the sink; if the
// previous result is still held when a request is ready to execute, the
// request waits until that beat is taken. No clearing pass follows reset.
module inode_cache_refcount_table (
    input  logic                              clk,
    input  logic                              rst_n,
    // Request channel
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [icrt_pkg::S_TDATA_W-1:0]    s_axis_tdata,   // [15:0] inode_id
    input  logic [icrt_pkg::OP_W-1:0]         s_axis_tuser,   // [1:0] opcode
    // Result channel
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [icrt_pkg::M_TDATA_W-1:0]    m_axis_tdata,   // [7:0] ref_count, [10:8] slot
    output logic [icrt_pkg::STATUS_W-1:0]     m_axis_tuser    // [2:0] status
);

    icrt_pkg::icrt_cmd_t                  cmd;
    logic [icrt_pkg::REFS_W-1:0]          ref_count;
    logic [icrt_pkg::SLOT_OUT_W-1:0]      slot;

    // Sequence capture and execution
    icrt_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd)
    );

    // Table, free queue and result register
    icrt_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .in_opcode     (s_axis_tuser),
        .in_inode_id   (s_axis_tdata[icrt_pkg::INODE_W-1:0]),
        .out_status    (m_axis_tuser),
        .out_ref_count (ref_count),
        .out_slot      (slot)
    );

    // Pack the result beat, zero-filled to whole bytes
    assign m_axis_tdata = {
        {(icrt_pkg::M_TDATA_W - icrt_pkg::REFS_W - icrt_pkg::SLOT_OUT_W){1'b0}},
        slot,
        ref_count
    };

endmodule

[rtl/core/icrt_ctrl.sv]
// Controller state machine: request capture, execute slot and output beat valid.
module icrt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output icrt_pkg::icrt_cmd_t   cmd
);

    icrt_pkg::ctrl_state_t state_reg;
    icrt_pkg::ctrl_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    // State and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= icrt_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        s_axis_tready  = 1'b0;

        // Drop the result beat once the sink takes it
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            icrt_pkg::S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = icrt_pkg::S_EXEC;
                end
            end
            icrt_pkg::S_EXEC:
            begin
                // Run the request only when the output register is free or its beat is being taken
                if (!out_valid_reg || m_axis_tready)
                begin
                    cmd.execute    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = icrt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = icrt_pkg::S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;

    // A request that executes leaves a result beat and returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |=> (out_valid_reg && state_reg == icrt_pkg::S_IDLE))
        else $error("execute did not produce a result beat");

    // Capture and execute never coincide
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.capture && cmd.execute))
        else $error("capture and execute in the same cycle");

endmodule

[rtl/core/icrt_datapath.sv]
// Datapath: inode table, free queue, request register and result register.
module icrt_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  icrt_pkg::icrt_cmd_t                cmd,
    input  logic [icrt_pkg::OP_W-1:0]          in_opcode,
    input  logic [icrt_pkg::INODE_W-1:0]       in_inode_id,
    output logic [icrt_pkg::STATUS_W-1:0]      out_status,
    output logic [icrt_pkg::REFS_W-1:0]        out_ref_count,
    output logic [icrt_pkg::SLOT_OUT_W-1:0]    out_slot
);

    localparam int N     = icrt_pkg::POOL_SIZE;
    localparam int SW    = icrt_pkg::SLOT_W;
    localparam int CW    = icrt_pkg::CNT_W;
    localparam int RW    = icrt_pkg::REFS_W;

    // Request register
    icrt_pkg::opcode_t                 req_op_reg;
    logic [icrt_pkg::INODE_W-1:0]      req_id_reg;

    // Table state
    logic                              valid_reg  [N];
    logic [icrt_pkg::INODE_W-1:0]      inode_reg  [N];
    logic [RW-1:0]                     refs_reg   [N];
    logic                              locked_reg [N];

    // Free queue, head at position 0
    logic [SW-1:0]                     queue_reg  [N];
    logic [SW-1:0]                     queue_next [N];
    logic [CW-1:0]                     qcount_reg;
    logic [CW-1:0]                     qcount_next;

    // Result register
    icrt_pkg::status_t                 status_reg;
    logic [RW-1:0]                     ref_out_reg;
    logic [icrt_pkg::SLOT_OUT_W-1:0]   slot_out_reg;

    // Lookup
    logic                              hit;
    logic [SW-1:0]                     hit_slot;
    logic                              free_any;
    logic [SW-1:0]                     free_slot;
    logic [RW-1:0]                     cur_refs;
    logic                              cur_locked;

    // Decision
    icrt_pkg::status_t                 status_next;
    logic [RW-1:0]                     res_refs;
    logic [SW-1:0]                     act_slot;
    logic                              fill;
    logic                              set_refs;
    logic [RW-1:0]                     new_refs;
    logic                              set_lock;
    logic                              new_lock;
    logic                              do_remove;
    logic                              do_append;

    // Queue removal
    logic                              rm_found;
    logic [SW-1:0]                     rm_pos;

    // Capture the request beat
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_op_reg <= icrt_pkg::opcode_t'(in_opcode);
            req_id_reg <= in_inode_id;
        end
    end

    // Associative lookup and lowest unused slot
    always_comb
    begin
        hit       = 1'b0;
        hit_slot  = '0;
        free_any  = 1'b0;
        free_slot = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && inode_reg[i] == req_id_reg)
            begin
                hit      = 1'b1;
                hit_slot = SW'(i);
            end
            if (!valid_reg[i])
            begin
                free_any  = 1'b1;
                free_slot = SW'(i);
            end
        end
        cur_refs   = refs_reg[hit_slot];
        cur_locked = locked_reg[hit_slot];
    end

    // Decide the outcome of the request
    always_comb
    begin
        status_next = icrt_pkg::ST_OK;
        res_refs    = cur_refs;
        act_slot    = hit_slot;
        fill        = 1'b0;
        set_refs    = 1'b0;
        new_refs    = cur_refs;
        set_lock    = 1'b0;
        new_lock    = cur_locked;
        do_remove   = 1'b0;
        do_append   = 1'b0;

        if (req_op_reg != icrt_pkg::OP_GET && !hit)
        begin
            status_next = icrt_pkg::ST_ABSENT;
            res_refs    = '0;
            act_slot    = '0;
        end
        else
        begin
            case (req_op_reg)
                icrt_pkg::OP_GET:
                begin
                    if (hit)
                    begin
                        if (cur_locked)
                            status_next = icrt_pkg::ST_WAIT;
                        else if (cur_refs == '1)
                            status_next = icrt_pkg::ST_LIMIT;
                        else
                        begin
                            // A zero-count entry leaves the free queue
                            do_remove = (cur_refs == '0);
                            set_refs  = 1'b1;
                            new_refs  = cur_refs + RW'(1);
                            res_refs  = new_refs;
                        end
                    end
                    else if (free_any)
                    begin
                        act_slot = free_slot;
                        fill     = 1'b1;
                        res_refs = RW'(1);
                    end
                    else if (qcount_reg != '0)
                    begin
                        // Evict the least recently released entry
                        act_slot  = queue_reg[0];
                        fill      = 1'b1;
                        do_remove = 1'b1;
                        res_refs  = RW'(1);
                    end
                    else
                    begin
                        status_next = icrt_pkg::ST_FULL;
                        res_refs    = '0;
                        act_slot    = '0;
                    end
                end
                icrt_pkg::OP_LOCK:
                begin
                    if (cur_locked)
                        status_next = icrt_pkg::ST_LOCKED;
                    else
                    begin
                        set_lock = 1'b1;
                        new_lock = 1'b1;
                    end
                end
                icrt_pkg::OP_UNLOCK:
                begin
                    if (!cur_locked)
                        status_next = icrt_pkg::ST_UNLOCKED;
                    else
                    begin
                        set_lock = 1'b1;
                        new_lock = 1'b0;
                    end
                end
                icrt_pkg::OP_PUT:
                begin
                    if (cur_locked)
                        status_next = icrt_pkg::ST_LOCKED;
                    else if (cur_refs == '0)
                    begin
                        status_next = icrt_pkg::ST_UNREF;
                        res_refs    = '0;
                    end
                    else
                    begin
                        // Queue the entry at the tail when its count reaches zero
                        set_refs  = 1'b1;
                        new_refs  = cur_refs - RW'(1);
                        res_refs  = new_refs;
                        do_append = (new_refs == '0);
                    end
                end
                default:
                begin
                    status_next = icrt_pkg::ST_ABSENT;
                    res_refs    = '0;
                    act_slot    = '0;
                end
            endcase
        end
    end

    // Free queue update: remove one slot with shift, or append at the tail
    always_comb
    begin
        rm_found = 1'b0;
        rm_pos   = '0;
        for (int j = N - 1; j >= 0; j--)
        begin
            if (CW'(j) < qcount_reg && queue_reg[j] == act_slot)
            begin
                rm_found = 1'b1;
                rm_pos   = SW'(j);
            end
        end

        for (int j = 0; j < N; j++)
            queue_next[j] = queue_reg[j];
        qcount_next = qcount_reg;

        if (do_remove && rm_found)
        begin
            for (int j = 0; j < N - 1; j++)
            begin
                if (SW'(j) >= rm_pos)
                    queue_next[j] = queue_reg[j + 1];
            end
            qcount_next = qcount_reg - CW'(1);
        end
        else if (do_append && qcount_reg < CW'(N))
        begin
            queue_next[qcount_reg[SW-1:0]] = act_slot;
            qcount_next = qcount_reg + CW'(1);
        end
    end

    // Table control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                valid_reg[i]  <= 1'b0;
                refs_reg[i]   <= '0;
                locked_reg[i] <= 1'b0;
            end
            qcount_reg <= '0;
        end
        else if (cmd.execute)
        begin
            if (fill)
            begin
                valid_reg[act_slot]  <= 1'b1;
                refs_reg[act_slot]   <= RW'(1);
                locked_reg[act_slot] <= 1'b0;
            end
            if (set_refs)
                refs_reg[act_slot] <= new_refs;
            if (set_lock)
                locked_reg[act_slot] <= new_lock;
            qcount_reg <= qcount_next;
        end
    end

    // Inode numbers and queue contents
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            if (fill)
                inode_reg[act_slot] <= req_id_reg;
            for (int j = 0; j < N; j++)
                queue_reg[j] <= queue_next[j];
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            status_reg   <= status_next;
            ref_out_reg  <= res_refs;
            slot_out_reg <= icrt_pkg::SLOT_OUT_W'(act_slot);
        end
    end

    assign out_status    = status_reg;
    assign out_ref_count = ref_out_reg;
    assign out_slot      = slot_out_reg;

    // Free queue never holds more slots than the table has
    assert property (@(posedge clk) disable iff (!rst_n)
        qcount_reg <= CW'(N))
        else $error("free queue count beyond pool size");

    // A successful get always leaves a nonzero count
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute && req_op_reg == icrt_pkg::OP_GET
            && status_next == icrt_pkg::ST_OK) |=> (ref_out_reg != '0))
        else $error("get returned zero count");

    // Absent and full results carry zero count and slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute && (status_next == icrt_pkg::ST_ABSENT
            || status_next == icrt_pkg::ST_FULL))
            |=> (ref_out_reg == '0 && slot_out_reg == '0))
        else $error("absent or full result with nonzero fields");

    // Removal from the queue only happens for a queued slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute && do_remove) |-> rm_found)
        else $error("removal of a slot that is not queued");

endmodule
